FILE: design/global_sequence_alignment_top_defines.svh
// Assertion macros for the alignment block
`ifndef GLOBAL_SEQUENCE_ALIGNMENT_TOP_DEFINES_SVH
`define GLOBAL_SEQUENCE_ALIGNMENT_TOP_DEFINES_SVH

`define GSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gsa_pkg.sv
package gsa_pkg;

  localparam int MaxLen = 32;
  localparam int Dim    = MaxLen + 1;
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int IdxW   = $clog2(MaxLen);
  localparam int MovesW = $clog2(Dim * Dim);
  localparam int PathW  = $clog2(2 * MaxLen);
  localparam int PlenW  = $clog2(2 * MaxLen + 1);
  localparam int ScoreW = 11;

  localparam logic [1:0] CmdLoadFirst  = 2'd0;
  localparam logic [1:0] CmdLoadSecond = 2'd1;
  localparam logic [1:0] CmdRun        = 2'd2;

  localparam logic [1:0] MoveDiag = 2'd0;
  localparam logic [1:0] MoveUp   = 2'd1;
  localparam logic [1:0] MoveLeft = 2'd2;

  localparam logic [2:0] SymGap = 3'd4;

  typedef enum logic [3:0] {
    StIdle, StEmpty, StInit, StRowStart, StCell, StCellWr, StTrace, StTraceWr, StEmit, StEmitWr
  } state_e;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start_run;
    logic init_col;
    logic row_start;
    logic cell_rd;
    logic cell_wr;
    logic trace_rd;
    logic trace_wr;
    logic emit_rd;
    logic emit_out;
    logic empty_out;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic init_done;
    logic rows_done;
    logic row_done;
    logic no_cols;
    logic trace_done;
    logic emit_done;
  } stat_t;

endpackage

FILE: design/global_sequence_alignment_top.sv
// Global alignment of two DNA sequences of up to 32 bases each.
// Command channel: a transaction is taken at a clock edge with start high and busy low.
// Load commands append one base each and keep busy low; loads past 32
// are dropped. Commands are sequential: a run holds busy high until its last pair.
// A run with n and m bases fills the score matrix, traces back a path of L steps,
// then emits the aligned pairs one at a time on done_o, each through the StEmit and
// StEmitWr states, in order from the sequence starts. Busy is low again in the same
// cycle that the last pair is on done_o.
// The final pair carries last_o, the total score and gap counts.
// A run with no bases loaded gives one transaction with pair_valid_o low, registered
// from the StEmpty state.
// Both lengths clear when a run starts; stored bases remain.
// gap_we_i/gap_wdata_i write the signed gap score; reset sets it to -2.
// Reset clears the lengths and control state. Results cannot be held off:
// each lasts one cycle on done_o.
module global_sequence_alignment_top
  import gsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [1:0]         base_i,
  input  logic               gap_we_i,
  input  logic [4:0]         gap_wdata_i,
  output logic               done_o,
  output logic               pair_valid_o,
  output logic [2:0]         aligned_first_o,
  output logic [2:0]         aligned_second_o,
  output logic signed [10:0] total_score_o,
  output logic [5:0]         insertion_count_o,
  output logic [5:0]         deletion_count_o,
  output logic               last_o
);

  `include "global_sequence_alignment_top_defines.svh"

  ctrl_t ctrl;
  stat_t stat;
  logic  both_gap;

  gsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cmd_i, .stat_i(stat), .busy_o(busy), .ctrl_o(ctrl)
  );

  gsa_datapath u_dp (
    .clk_i, .rst_ni, .base_i, .gap_we_i, .gap_wdata_i, .ctrl_i(ctrl), .stat_o(stat),
    .done_o, .pair_valid_o, .aligned_first_o, .aligned_second_o, .total_score_o,
    .insertion_count_o, .deletion_count_o, .last_o
  );

  assign both_gap = (aligned_first_o == SymGap) && (aligned_second_o == SymGap);

  `GSA_ASSERT(a_last_has_done, last_o |-> done_o, "last without result")
  `GSA_ASSERT(a_gap_sym, (done_o && pair_valid_o) |-> !both_gap, "double gap")
  `GSA_ASSERT_NEXT(a_run_busy, start && !busy && cmd_i == CmdRun, busy, "run not busy")

endmodule

FILE: design/gsa_ctrl.sv
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  stat_t       stat_i,
  output logic        busy_o,
  output ctrl_t       ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && cmd_i == CmdRun) begin
          state_d = stat_i.empty ? StEmpty : StInit;
        end
      end
      StEmpty:    state_d = StIdle;
      StInit:     state_d = stat_i.init_done ? StRowStart : StInit;
      StRowStart: state_d = stat_i.rows_done ? StTrace :
                            (stat_i.no_cols ? StRowStart : StCell);
      StCell:     state_d = StCellWr;
      StCellWr:   state_d = stat_i.row_done ? StRowStart : StCell;
      StTrace:    state_d = stat_i.trace_done ? StEmit : StTraceWr;
      StTraceWr:  state_d = StTrace;
      StEmit:     state_d = StEmitWr;
      StEmitWr:   state_d = stat_i.emit_done ? StIdle : StEmit;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        ctrl_o.load_first  = start_i && cmd_i == CmdLoadFirst;
        ctrl_o.load_second = start_i && cmd_i == CmdLoadSecond;
        ctrl_o.start_run   = start_i && cmd_i == CmdRun;
      end
      StEmpty:    ctrl_o.empty_out = 1'b1;
      StInit:     ctrl_o.init_col  = 1'b1;
      StRowStart: ctrl_o.row_start = 1'b1;
      StCell:     ctrl_o.cell_rd   = 1'b1;
      StCellWr:   ctrl_o.cell_wr   = 1'b1;
      StTrace:    ctrl_o.trace_rd  = 1'b1;
      StTraceWr:  ctrl_o.trace_wr  = 1'b1;
      StEmit:     ctrl_o.emit_rd   = 1'b1;
      StEmitWr:   ctrl_o.emit_out  = 1'b1;
      default:    ctrl_o = '0;
    endcase
  end

endmodule

FILE: design/gsa_datapath.sv
module gsa_datapath
  import gsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        base_i,
  input  logic              gap_we_i,
  input  logic [4:0]        gap_wdata_i,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  output logic              done_o,
  output logic              pair_valid_o,
  output logic [2:0]        aligned_first_o,
  output logic [2:0]        aligned_second_o,
  output logic signed [10:0] total_score_o,
  output logic [5:0]        insertion_count_o,
  output logic [5:0]        deletion_count_o,
  output logic              last_o
);

  logic [1:0] first_mem [MaxLen];
  logic [1:0] second_mem [MaxLen];
  logic signed [ScoreW-1:0] row_mem [Dim];
  logic [1:0] move_mem [Dim*Dim];
  logic [1:0] path_mem [2*MaxLen];

  logic signed [4:0] gap_q;
  logic [LenW-1:0] flen_q, slen_q, n_q, m_q;
  logic [LenW-1:0] i_q, j_q;
  logic signed [ScoreW-1:0] diag_q, left_q, upsc_q;
  logic [1:0] fb_q, sb_q, mv_q;
  logic [PlenW-1:0] len_q, k_q;
  logic [5:0] ins_q, del_q;
  logic signed [ScoreW-1:0] total_q;
  logic [MovesW-1:0] cell_addr;
  logic signed [ScoreW-1:0] gx, up_c, dg_c, lf_c, best;
  logic [1:0] mv_c, tmv;
  logic [2:0] a_c, b_c;
  logic out_q, pv_q, last_q;
  logic [2:0] oa_q, ob_q;

  assign gx = ScoreW'(gap_q);
  assign cell_addr = MovesW'(i_q) * MovesW'(Dim) + MovesW'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= -5'sd2;
      flen_q <= '0;
      slen_q <= '0;
    end else begin
      if (gap_we_i) gap_q <= gap_wdata_i;
      if (ctrl_i.load_first && flen_q < LenW'(MaxLen)) flen_q <= flen_q + 1'b1;
      if (ctrl_i.load_second && slen_q < LenW'(MaxLen)) slen_q <= slen_q + 1'b1;
      if (ctrl_i.start_run) begin
        flen_q <= '0;
        slen_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_first && flen_q < LenW'(MaxLen)) first_mem[flen_q[IdxW-1:0]] <= base_i;
    if (ctrl_i.load_second && slen_q < LenW'(MaxLen)) second_mem[slen_q[IdxW-1:0]] <= base_i;
  end

  assign stat_o.empty      = (flen_q == '0) && (slen_q == '0);
  assign stat_o.init_done  = (j_q == m_q);
  assign stat_o.rows_done  = (i_q == n_q);
  assign stat_o.row_done   = (j_q == m_q);
  assign stat_o.no_cols    = (m_q == '0);
  assign stat_o.trace_done = (i_q == '0) && (j_q == '0);
  assign stat_o.emit_done  = (k_q == len_q - 1'b1);

  assign up_c = upsc_q + gx;
  assign dg_c = diag_q + ((fb_q == sb_q) ? 11'sd1 : -11'sd1);
  assign lf_c = left_q + gx;

  always_comb begin
    best = up_c;
    if (dg_c > best) best = dg_c;
    if (lf_c > best) best = lf_c;
    priority if (best == up_c) mv_c = MoveUp;
    else if (best == dg_c)     mv_c = MoveDiag;
    else                       mv_c = MoveLeft;
  end

  always_comb begin
    tmv = mv_q;
    if (i_q == '0) tmv = MoveLeft;
    else if (j_q == '0) tmv = MoveUp;
  end

  always_comb begin
    unique case (mv_q)
      MoveUp: begin
        a_c = {1'b0, fb_q};
        b_c = SymGap;
      end
      MoveLeft: begin
        a_c = SymGap;
        b_c = {1'b0, sb_q};
      end
      default: begin
        a_c = {1'b0, fb_q};
        b_c = {1'b0, sb_q};
      end
    endcase
  end

  // main sequencing datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_run) begin
      n_q  <= flen_q;
      m_q  <= slen_q;
      i_q  <= '0;
      j_q  <= '0;
      left_q <= '0;
      row_mem[0] <= '0;
    end
    if (ctrl_i.init_col) begin
      if (j_q != m_q) begin
        row_mem[j_q + 1'b1] <= left_q + gx;
        left_q <= left_q + gx;
        j_q <= j_q + 1'b1;
      end
    end
    if (ctrl_i.row_start) begin
      if (i_q == n_q) begin
        total_q <= row_mem[m_q];
        i_q <= n_q;
        j_q <= m_q;
        len_q <= '0;
      end else begin
        diag_q <= row_mem[0];
        left_q <= row_mem[0] + gx;
        row_mem[0] <= row_mem[0] + gx;
        fb_q <= first_mem[i_q[IdxW-1:0]];
        i_q <= i_q + 1'b1;
        j_q <= '0;
      end
    end
    if (ctrl_i.cell_rd) begin
      upsc_q <= row_mem[j_q + 1'b1];
      sb_q <= second_mem[j_q[IdxW-1:0]];
      j_q <= j_q + 1'b1;
    end
    if (ctrl_i.cell_wr) begin
      row_mem[j_q] <= best;
      move_mem[cell_addr] <= mv_c;
      diag_q <= upsc_q;
      left_q <= best;
    end
    if (ctrl_i.trace_rd) begin
      mv_q <= move_mem[cell_addr];
    end
    if (ctrl_i.trace_wr) begin
      path_mem[len_q[PathW-1:0]] <= tmv;
      len_q <= len_q + 1'b1;
      if (tmv != MoveLeft) i_q <= i_q - 1'b1;
      if (tmv != MoveUp) j_q <= j_q - 1'b1;
      if (stat_o.trace_done) begin
        i_q <= '0;
      end
    end
    if (ctrl_i.trace_rd && stat_o.trace_done) begin
      k_q <= '0;
      ins_q <= '0;
      del_q <= '0;
    end
    if (ctrl_i.emit_rd) begin
      mv_q <= path_mem[PathW'(len_q - 1'b1 - k_q)];
      fb_q <= first_mem[i_q[IdxW-1:0]];
      sb_q <= second_mem[j_q[IdxW-1:0]];
    end
    if (ctrl_i.emit_out) begin
      if (mv_q != MoveLeft) i_q <= i_q + 1'b1;
      if (mv_q != MoveUp) j_q <= j_q + 1'b1;
      if (mv_q == MoveLeft) ins_q <= ins_q + 1'b1;
      if (mv_q == MoveUp) del_q <= del_q + 1'b1;
      k_q <= k_q + 1'b1;
      oa_q <= a_c;
      ob_q <= b_c;
    end
    if (ctrl_i.empty_out) begin
      oa_q <= '0;
      ob_q <= '0;
    end
  end

  logic [5:0] ins_n, del_n;
  assign ins_n = ins_q + ((mv_q == MoveLeft) ? 6'd1 : 6'd0);
  assign del_n = del_q + ((mv_q == MoveUp) ? 6'd1 : 6'd0);

  logic signed [ScoreW-1:0] ts_q;
  logic [5:0] io_q, do_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_out) begin
      ts_q <= stat_o.emit_done ? total_q : '0;
      io_q <= stat_o.emit_done ? ins_n : '0;
      do_q <= stat_o.emit_done ? del_n : '0;
    end
    if (ctrl_i.empty_out) begin
      ts_q <= '0;
      io_q <= '0;
      do_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= 1'b0;
      pv_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      out_q  <= ctrl_i.emit_out || ctrl_i.empty_out;
      pv_q   <= ctrl_i.emit_out;
      last_q <= ctrl_i.empty_out || (ctrl_i.emit_out && stat_o.emit_done);
    end
  end

  assign done_o            = out_q;
  assign pair_valid_o      = pv_q;
  assign aligned_first_o   = oa_q;
  assign aligned_second_o  = ob_q;
  assign total_score_o     = ts_q;
  assign insertion_count_o = io_q;
  assign deletion_count_o  = do_q;
  assign last_o            = last_q;

endmodule
